### hw/rtl/pfbd_pkg.sv
// ----------------------------------------------------------------------------
// pfbd_pkg: shared types and constants of the pulse filter beat detector
// Field widths, reset values of the peak tracker and configuration register
// indexes used across the block.
// ----------------------------------------------------------------------------
package pfbd_pkg;

   localparam int SAMPLE_W    = 18;
   localparam int AC_W        = 16;
   localparam int AMP_W       = 15;
   localparam int DC_TOTAL_W  = 24;
   localparam int AMP_TOTAL_W = 17;
   localparam int AMP_DIV_SHIFT = 2;
   localparam int CSR_IDX_W   = 2;

   typedef logic        [SAMPLE_W-1:0]  sample_type;
   typedef logic signed [AC_W-1:0]      ac_type;
   typedef logic        [AMP_W-1:0]     amp_type;
   typedef logic        [CSR_IDX_W-1:0] csr_idx_type;

   localparam csr_idx_type CSR_AMP_MIN = 2'd0;
   localparam csr_idx_type CSR_AMP_MAX = 2'd1;

   localparam amp_type AMP_MIN_RESET = 15'd20;
   localparam amp_type AMP_MAX_RESET = 15'd3000;

   localparam ac_type PEAK_HIGH_RESET = 16'sd20;
   localparam ac_type PEAK_LOW_RESET  = -16'sd20;

endpackage

### hw/rtl/pulse_filter_beat_detector_top.sv
// ----------------------------------------------------------------------------
// pulse_filter_beat_detector_top: optical pulse filter and beat detector
// Removes the DC level from raw optical samples, smooths the AC part with a
// moving average and flags heartbeats from the slope of the smoothed signal.
// ----------------------------------------------------------------------------
// Usage:
// Each item on the req_ channel carries one raw 18-bit sample. Each accepted
// item yields exactly one item on the rsp_ channel with the AC value, the
// smoothed value, the beat flag, the DC level and the averaged beat amplitude.
// Both channels use valid/ready; an item moves when valid and ready are high.
// The datapath is three register stages: DC estimate, moving average and
// peak tracking. The last stage is the result register. A result passes the
// DC, smoothing and peak registers before it shows on rsp_, and one item per
// cycle flows through while rsp_ready stays high; the rate is set by each
// stage updating its state as it accepts an item (leaky total, running
// window sum, peak tracker). When the receiver stalls, the stages fill one
// by one; req_ready drops only once all three hold an item, so up to three
// items sit in the block. The csr_ port writes the beat limits amp_min and
// amp_max; write them only while no item is in flight. A synchronous reset
// empties the pipeline, clears all filter state and restores the limits.
// ----------------------------------------------------------------------------
module pulse_filter_beat_detector_top #(
   parameter int DC_DEPTH  = 24,
   parameter int AVG_SLOTS = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  pfbd_pkg::sample_type  req_raw_sample,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output pfbd_pkg::ac_type      rsp_ac_signal,
   output pfbd_pkg::ac_type      rsp_smoothed,
   output logic                  rsp_beat,
   output pfbd_pkg::sample_type  rsp_dc_level,
   output pfbd_pkg::amp_type     rsp_ac_level,
   input  logic                  csr_write_en,
   input  pfbd_pkg::csr_idx_type csr_index,
   input  pfbd_pkg::amp_type     csr_write_data
);
   import pfbd_pkg::*;

   // Beat limits; writes to an unknown index are dropped.
   amp_type amp_min_ff;
   amp_type amp_max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         amp_min_ff <= AMP_MIN_RESET;
         amp_max_ff <= AMP_MAX_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_AMP_MIN: amp_min_ff <= csr_write_data;
            CSR_AMP_MAX: amp_max_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Stage 1 to stage 2.
   logic       dc_valid;
   logic       dc_ready;
   sample_type dc_sample;
   sample_type dc_level;

   // Stage 2 to stage 3.
   logic       sm_valid;
   logic       sm_ready;
   ac_type     sm_ac;
   ac_type     sm_value;
   sample_type sm_dc;

   pfbd_dc_remover #(
      .DC_DEPTH (DC_DEPTH)
   ) u_dc_remover (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_sample  (req_raw_sample),
      .out_valid  (dc_valid),
      .out_ready  (dc_ready),
      .out_sample (dc_sample),
      .out_dc     (dc_level)
   );

   pfbd_smoother #(
      .AVG_SLOTS (AVG_SLOTS)
   ) u_smoother (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (dc_valid),
      .in_ready     (dc_ready),
      .in_sample    (dc_sample),
      .in_dc        (dc_level),
      .out_valid    (sm_valid),
      .out_ready    (sm_ready),
      .out_ac       (sm_ac),
      .out_smoothed (sm_value),
      .out_dc       (sm_dc)
   );

   pfbd_peak_detect u_peak_detect (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (sm_valid),
      .in_ready     (sm_ready),
      .in_ac        (sm_ac),
      .in_smoothed  (sm_value),
      .in_dc        (sm_dc),
      .amp_min      (amp_min_ff),
      .amp_max      (amp_max_ff),
      .out_valid    (rsp_valid),
      .out_ready    (rsp_ready),
      .out_ac       (rsp_ac_signal),
      .out_smoothed (rsp_smoothed),
      .out_beat     (rsp_beat),
      .out_dc       (rsp_dc_level),
      .out_ac_level (rsp_ac_level)
   );

endmodule

### hw/rtl/pfbd_dc_remover.sv
// ----------------------------------------------------------------------------
// pfbd_dc_remover: leaky-integrator DC estimate
// Updates the leaky total with each accepted sample and registers the sample
// together with the new DC level (total divided by the depth).
// ----------------------------------------------------------------------------
module pfbd_dc_remover #(
   parameter int DC_DEPTH = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  pfbd_pkg::sample_type in_sample,
   output logic                 out_valid,
   input  logic                 out_ready,
   output pfbd_pkg::sample_type out_sample,
   output pfbd_pkg::sample_type out_dc
);
   import pfbd_pkg::*;

   // Division by the depth is a multiplication by a rounded-up reciprocal.
   // With this shift the quotient is exact for every 24-bit total.
   localparam int SHIFT  = DC_TOTAL_W + $clog2(DC_DEPTH);
   localparam int MULT_W = DC_TOTAL_W + 1;
   localparam int PROD_W = DC_TOTAL_W + MULT_W;
   localparam longint unsigned MULT_FULL = ((64'd1 << SHIFT) + DC_DEPTH - 1) / DC_DEPTH;
   localparam logic [MULT_W-1:0] MULT = MULT_W'(MULT_FULL);

   logic                  valid_ff, valid_in;
   logic [DC_TOTAL_W-1:0] total_ff, total_in;
   sample_type            dc_ff, dc_in;
   sample_type            sample_ff;
   logic [PROD_W-1:0]     prod;
   logic [PROD_W-1:0]     prod_shr;
   logic                  load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   // The total stays below 2^18 times the depth, so its quotient fits 18 bits.
   assign total_in = total_ff + DC_TOTAL_W'(in_sample) - DC_TOTAL_W'(dc_ff);
   assign prod     = PROD_W'(total_in) * PROD_W'(MULT);
   assign prod_shr = prod >> SHIFT;
   assign dc_in    = prod_shr[SAMPLE_W-1:0];

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         total_ff <= '0;
         dc_ff    <= '0;
      end else begin
         valid_ff <= valid_in;
         if (load) begin
            total_ff <= total_in;
            dc_ff    <= dc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sample_ff <= in_sample;
      end
   end

   assign out_valid  = valid_ff;
   assign out_sample = sample_ff;
   assign out_dc     = dc_ff;

endmodule

### hw/rtl/pfbd_smoother.sv
// ----------------------------------------------------------------------------
// pfbd_smoother: AC extraction and moving average
// Forms the AC value, keeps a ring of recent AC values with a running 16-bit
// sum, and divides the sum by the ring size, truncating toward zero.
// ----------------------------------------------------------------------------
module pfbd_smoother #(
   parameter int AVG_SLOTS = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  pfbd_pkg::sample_type in_sample,
   input  pfbd_pkg::sample_type in_dc,
   output logic                 out_valid,
   input  logic                 out_ready,
   output pfbd_pkg::ac_type     out_ac,
   output pfbd_pkg::ac_type     out_smoothed,
   output pfbd_pkg::sample_type out_dc
);
   import pfbd_pkg::*;

   localparam int SLOT_W  = $clog2(AVG_SLOTS);
   localparam int ASHIFT  = AC_W + $clog2(AVG_SLOTS);
   localparam int AMULT_W = AC_W + 1;
   localparam int PROD_W  = AC_W + AMULT_W;
   localparam longint unsigned AMULT_FULL = ((64'd1 << ASHIFT) + AVG_SLOTS - 1) / AVG_SLOTS;
   localparam logic [AMULT_W-1:0] AMULT = AMULT_W'(AMULT_FULL);
   localparam logic [SLOT_W-1:0]  LAST_SLOT = SLOT_W'(AVG_SLOTS - 1);

   logic              valid_ff, valid_in;
   logic [AC_W-1:0]   win_ff [AVG_SLOTS];
   logic [AC_W-1:0]   sum_ff, sum_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   ac_type            ac_ff;
   ac_type            sm_ff, sm_in;
   sample_type        dc_ff;
   sample_type        diff;
   logic [AC_W-1:0]   ac_in;
   logic [AC_W-1:0]   mag;
   logic [PROD_W-1:0] prod;
   logic [PROD_W-1:0] prod_shr;
   logic [AC_W-1:0]   quo;
   logic              load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   assign diff  = in_sample - in_dc;
   assign ac_in = diff[AC_W-1:0];

   // The running sum drops the value that the new one replaces.
   assign sum_in  = sum_ff - win_ff[slot_ff] + ac_in;
   assign slot_in = (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;

   // Signed division toward zero: divide the magnitude, restore the sign.
   assign mag      = sum_in[AC_W-1] ? (~sum_in + 1'b1) : sum_in;
   assign prod     = PROD_W'(mag) * PROD_W'(AMULT);
   assign prod_shr = prod >> ASHIFT;
   assign quo      = prod_shr[AC_W-1:0];
   assign sm_in    = sum_in[AC_W-1] ? $signed(~quo + 1'b1) : $signed(quo);

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sum_ff   <= '0;
         slot_ff  <= '0;
         for (int i = 0; i < AVG_SLOTS; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         if (load) begin
            sum_ff          <= sum_in;
            slot_ff         <= slot_in;
            win_ff[slot_ff] <= ac_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ac_ff <= $signed(ac_in);
         sm_ff <= sm_in;
         dc_ff <= in_dc;
      end
   end

   assign out_valid    = valid_ff;
   assign out_ac       = ac_ff;
   assign out_smoothed = sm_ff;
   assign out_dc       = dc_ff;

endmodule

### hw/rtl/pfbd_peak_detect.sv
// ----------------------------------------------------------------------------
// pfbd_peak_detect: slope tracking, beat qualification and result register
// Tracks the slope of the smoothed signal and its extremes, flags a beat on a
// qualified turn from rising to falling and keeps the amplitude average.
// ----------------------------------------------------------------------------
module pfbd_peak_detect (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  pfbd_pkg::ac_type     in_ac,
   input  pfbd_pkg::ac_type     in_smoothed,
   input  pfbd_pkg::sample_type in_dc,
   input  pfbd_pkg::amp_type    amp_min,
   input  pfbd_pkg::amp_type    amp_max,
   output logic                 out_valid,
   input  logic                 out_ready,
   output pfbd_pkg::ac_type     out_ac,
   output pfbd_pkg::ac_type     out_smoothed,
   output logic                 out_beat,
   output pfbd_pkg::sample_type out_dc,
   output pfbd_pkg::amp_type    out_ac_level
);
   import pfbd_pkg::*;

   logic                    valid_ff, valid_in;
   logic                    rising_ff, rising_in;
   ac_type                  last_ff;
   ac_type                  high_ff, high_in;
   ac_type                  low_ff, low_in;
   logic [AMP_TOTAL_W-1:0]  amp_total_ff, amp_total_in;
   logic                    beat_ff, beat_in;
   ac_type                  ac_ff;
   sample_type              dc_ff;
   logic signed [AC_W:0]    amp;
   logic signed [AC_W:0]    lim_lo;
   logic signed [AC_W:0]    lim_hi;
   logic                    up;
   logic                    down;
   logic                    load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   assign up     = in_smoothed > last_ff;
   assign down   = in_smoothed < last_ff;
   assign amp    = {high_ff[AC_W-1], high_ff} - {low_ff[AC_W-1], low_ff};
   assign lim_lo = {2'b00, amp_min};
   assign lim_hi = {2'b00, amp_max};

   always_comb begin
      high_in      = high_ff;
      low_in       = low_ff;
      rising_in    = rising_ff;
      beat_in      = 1'b0;
      amp_total_in = amp_total_ff;
      if (rising_ff && up) begin
         high_in = in_smoothed;
      end
      if (!rising_ff && down) begin
         low_in = in_smoothed;
      end
      // Turn from rising to falling: a peak, counted when its swing qualifies.
      if (rising_ff && down) begin
         if (amp > lim_lo && amp < lim_hi) begin
            beat_in      = 1'b1;
            amp_total_in = amp_total_ff + AMP_TOTAL_W'(amp[AMP_W-1:0])
                           - AMP_TOTAL_W'(amp_total_ff[AMP_TOTAL_W-1:AMP_DIV_SHIFT]);
         end
         low_in    = '0;
         rising_in = 1'b0;
      end
      if (!rising_ff && up) begin
         high_in   = '0;
         rising_in = 1'b1;
      end
   end

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         rising_ff    <= 1'b0;
         last_ff      <= '0;
         high_ff      <= PEAK_HIGH_RESET;
         low_ff       <= PEAK_LOW_RESET;
         amp_total_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         if (load) begin
            rising_ff    <= rising_in;
            last_ff      <= in_smoothed;
            high_ff      <= high_in;
            low_ff       <= low_in;
            amp_total_ff <= amp_total_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         beat_ff <= beat_in;
         ac_ff   <= in_ac;
         dc_ff   <= in_dc;
      end
   end

   assign out_valid    = valid_ff;
   assign out_ac       = ac_ff;
   assign out_smoothed = last_ff;
   assign out_beat     = beat_ff;
   assign out_dc       = dc_ff;
   assign out_ac_level = amp_total_ff[AMP_TOTAL_W-1:AMP_DIV_SHIFT];

endmodule
